// ===== rtl/core/imm_pkg.sv =====
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, codes and sizes of the integer matrix multiply block.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 6;
  localparam int FUNC_W      = 2;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_IDX_W   = 3;
  localparam int BIT_CNT_W   = $clog2(DATA_W);

  localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_MUL,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic first;
    logic step;
  } mac_ctrl_t;

  typedef struct packed {
    logic                 fire;
    logic                 last;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
  } emit_t;

endpackage

// ===== rtl/core/imm_ram.sv =====
// ----------------------------------------------------------------------------
// imm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/imm_mac.sv =====
// ----------------------------------------------------------------------------
// imm_mac
// Bit-serial shift-and-add multiply accumulate, one multiplier bit per cycle while step is high.
// The low word of each product is added into the running sum.
// ----------------------------------------------------------------------------
module imm_mac (
  input  logic                       clk,
  input  imm_pkg::mac_ctrl_t         ctrl,
  input  logic [imm_pkg::DATA_W-1:0] a_word,
  input  logic [imm_pkg::DATA_W-1:0] b_word,
  output logic [imm_pkg::DATA_W-1:0] sum
);

  logic [imm_pkg::DATA_W-1:0] mcand;
  logic [imm_pkg::DATA_W-1:0] mplier;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand  <= a_word;
      mplier <= b_word;
      if (ctrl.first) begin
        sum <= '0;
      end
    end else if (ctrl.step) begin
      if (mplier[0]) begin
        sum <= sum + mcand;
      end
      mcand  <= {mcand[imm_pkg::DATA_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[imm_pkg::DATA_W-1:1]};
    end
  end

endmodule

// ===== rtl/core/imm_ctrl.sv =====
// ----------------------------------------------------------------------------
// imm_ctrl
// Sequencer of a compute run: walks rows, columns and the inner index,
// forms store addresses and drives the serial multiplier and result emit.
// ----------------------------------------------------------------------------
module imm_ctrl #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  start,
  input  logic [imm_pkg::CFG_W-1:0]                             rows_a,
  input  logic [imm_pkg::CFG_W-1:0]                             inner_len,
  input  logic [imm_pkg::CFG_W-1:0]                             cols_b,
  input  logic                                                  out_free,
  output logic                                                  busy,
  output logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] a_addr,
  output logic [(MAX_DIM*MAX_DIM > 1 ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] b_addr,
  output imm_pkg::mac_ctrl_t                                    mac,
  output imm_pkg::emit_t                                        emit
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam logic [imm_pkg::BIT_CNT_W-1:0] BIT_LAST =
    imm_pkg::BIT_CNT_W'(imm_pkg::DATA_W - 1);

  imm_pkg::ctrl_state_t state, state_next;

  logic [CNT_W-1:0]              dim_m, dim_k, dim_n;
  logic [CNT_W-1:0]              m, k, n;
  logic [CNT_W-1:0]              row_cnt, col_cnt, inr_cnt;
  logic [imm_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [ADDR_W-1:0]             a_base;
  logic                          inr_last, col_last, row_last;

  function automatic logic [CNT_W-1:0] clamp_dim(input logic [imm_pkg::CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > imm_pkg::CFG_W'(MAX_DIM)) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  assign dim_m = clamp_dim(rows_a);
  assign dim_k = clamp_dim(inner_len);
  assign dim_n = clamp_dim(cols_b);

  assign inr_last = (inr_cnt + 1'b1) == k;
  assign col_last = (col_cnt + 1'b1) == n;
  assign row_last = (row_cnt + 1'b1) == m;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac        = '0;
    emit.fire  = 1'b0;
    emit.last  = row_last && col_last;
    emit.row   = imm_pkg::OUT_IDX_W'(row_cnt);
    emit.col   = imm_pkg::OUT_IDX_W'(col_cnt);
    busy       = state != imm_pkg::ST_IDLE;
    unique case (state)
      imm_pkg::ST_IDLE: begin
        if (start) begin
          state_next = imm_pkg::ST_FETCH;
        end
      end
      imm_pkg::ST_FETCH: begin
        state_next = imm_pkg::ST_LOAD;
      end
      imm_pkg::ST_LOAD: begin
        mac.load   = 1'b1;
        mac.first  = inr_cnt == '0;
        state_next = imm_pkg::ST_MUL;
      end
      imm_pkg::ST_MUL: begin
        mac.step = 1'b1;
        if (bit_cnt == BIT_LAST) begin
          state_next = inr_last ? imm_pkg::ST_EMIT : imm_pkg::ST_FETCH;
        end
      end
      imm_pkg::ST_EMIT: begin
        if (out_free) begin
          emit.fire  = 1'b1;
          state_next = (row_last && col_last) ? imm_pkg::ST_IDLE : imm_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = imm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      inr_cnt <= '0;
      bit_cnt <= '0;
      a_base  <= '0;
      a_addr  <= '0;
      b_addr  <= '0;
      m       <= CNT_W'(1);
      k       <= CNT_W'(1);
      n       <= CNT_W'(1);
    end else begin
      if (state == imm_pkg::ST_IDLE && start) begin
        m       <= dim_m;
        k       <= dim_k;
        n       <= dim_n;
        row_cnt <= '0;
        col_cnt <= '0;
        inr_cnt <= '0;
        a_base  <= '0;
        a_addr  <= '0;
        b_addr  <= '0;
      end
      if (state == imm_pkg::ST_LOAD) begin
        bit_cnt <= '0;
      end
      if (state == imm_pkg::ST_MUL) begin
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == BIT_LAST && !inr_last) begin
          inr_cnt <= inr_cnt + 1'b1;
          a_addr  <= a_addr + 1'b1;
          b_addr  <= b_addr + ADDR_W'(n);
        end
      end
      if (emit.fire && !(row_last && col_last)) begin
        inr_cnt <= '0;
        if (col_last) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + 1'b1;
          a_base  <= a_base + ADDR_W'(k);
          a_addr  <= a_base + ADDR_W'(k);
          b_addr  <= '0;
        end else begin
          col_cnt <= col_cnt + 1'b1;
          a_addr  <= a_base;
          b_addr  <= ADDR_W'(col_cnt + 1'b1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/integer_matrix_multiply_top.sv =====
// ----------------------------------------------------------------------------
// integer_matrix_multiply_top
// Signed 32-bit matrix multiply C = A * B with bit-serial multiply accumulate.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   func, elem_index, elem_value
//   out      source     out_valid/out_stall prod_value, out_row, out_col, last_elem
//   cfg      sink       cfg_we              cfg_index, cfg_data
//
// Write words are stored while idle. For each product element a compute run
// does, per inner term, a store read (FETCH), an operand load (LOAD) and the
// serial multiply (MUL, one multiplier bit per cycle), then emits (EMIT).
// Reset returns the sequencer to idle and the dimensions to 8; stores are not
// cleared. in_stall is high for the whole compute run; a stalled result holds
// the sequencer at the end of its element.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_top #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [imm_pkg::FUNC_W-1:0]          func,
  input  logic [imm_pkg::IDX_W-1:0]           elem_index,
  input  logic signed [imm_pkg::DATA_W-1:0]   elem_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [imm_pkg::DATA_W-1:0]   prod_value,
  output logic [imm_pkg::OUT_IDX_W-1:0]       out_row,
  output logic [imm_pkg::OUT_IDX_W-1:0]       out_col,
  output logic                                last_elem,
  input  logic                                cfg_we,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imm_pkg::CFG_W-1:0]           cfg_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [imm_pkg::CFG_W-1:0]  rows_a, inner_len, cols_b;
  logic                       in_acc, idx_ok, we_a, we_b, start, busy, out_free;
  logic [ADDR_W-1:0]          a_addr, b_addr;
  logic [imm_pkg::DATA_W-1:0] a_word, b_word, sum;
  imm_pkg::mac_ctrl_t         mac;
  imm_pkg::emit_t             emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= imm_pkg::CFG_W'(8);
      inner_len <= imm_pkg::CFG_W'(8);
      cols_b    <= imm_pkg::CFG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        imm_pkg::CFG_ROWS_A:    rows_a    <= cfg_data;
        imm_pkg::CFG_INNER_LEN: inner_len <= cfg_data;
        imm_pkg::CFG_COLS_B:    cols_b    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = busy;
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = {1'b0, elem_index} < (imm_pkg::IDX_W + 1)'(DEPTH);
  assign we_a     = in_acc && func == imm_pkg::FUNC_WR_A && idx_ok;
  assign we_b     = in_acc && func == imm_pkg::FUNC_WR_B && idx_ok;
  assign start    = in_acc && func == imm_pkg::FUNC_COMPUTE;
  assign out_free = !out_valid || !out_stall;

  imm_ram #(
    .WIDTH (imm_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_a_store (
    .clk     (clk),
    .we      (we_a),
    .wr_addr (ADDR_W'(elem_index)),
    .wr_data (elem_value),
    .rd_addr (a_addr),
    .rd_data (a_word)
  );

  imm_ram #(
    .WIDTH (imm_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_b_store (
    .clk     (clk),
    .we      (we_b),
    .wr_addr (ADDR_W'(elem_index)),
    .wr_data (elem_value),
    .rd_addr (b_addr),
    .rd_data (b_word)
  );

  imm_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .rows_a    (rows_a),
    .inner_len (inner_len),
    .cols_b    (cols_b),
    .out_free  (out_free),
    .busy      (busy),
    .a_addr    (a_addr),
    .b_addr    (b_addr),
    .mac       (mac),
    .emit      (emit)
  );

  imm_mac u_mac (
    .clk    (clk),
    .ctrl   (mac),
    .a_word (a_word),
    .b_word (b_word),
    .sum    (sum)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.fire) begin
      prod_value <= sum;
      out_row    <= emit.row;
      out_col    <= emit.col;
      last_elem  <= emit.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit.fire |-> (!out_valid || !out_stall))
    else $error("result word overwritten while stalled");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit.fire |=> out_valid)
    else $error("emitted word not presented");

  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(in_valid && func == imm_pkg::FUNC_COMPUTE))
    else $error("compute run started without a compute word");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(we_a || we_b))
    else $error("store written during compute run");
`endif

endmodule
